// ===== hdl/dgpid_pkg.sv =====
// Shared constants and types for the dual-gain positional PID block.
package dgpid_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int VAL_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int DRIVE_W  = 12;
  localparam int ERR_W    = VAL_W + 1;        // setpoint - measured
  localparam int DIFF_W   = ERR_W + 1;        // previous_error - error
  localparam int INTEG_W  = 32;
  localparam int PPROP_W  = GAIN_W + ERR_W;
  localparam int PINT_W   = GAIN_W + INTEG_W;
  localparam int PDER_W   = GAIN_W + DIFF_W;
  localparam int ACC_W    = PINT_W + 2;
  localparam int FRAC_W   = 8;                // Q8.8 gains
  localparam int QUO_W    = ACC_W - FRAC_W;
  localparam int U_W      = 11;               // holds -1000..1000
  localparam int SUM_W    = DRIVE_W + 1;

  // Stream packing
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int NUM_REGS   = 6;

  // Mode codes
  localparam logic [CMD_W-1:0] MODE_DEPTH  = 3'd4;
  localparam logic [CMD_W-1:0] MODE_ORIENT = 3'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_KP  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_KI  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_KD  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIENT_KP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIENT_KI = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIENT_KD = 3'd5;

  // Output constants
  localparam logic signed [SUM_W-1:0] DRIVE_MID = 13'sd1500;
  localparam int DRIVE_LIM = 1000;
  localparam logic [DRIVE_W-1:0] DRIVE_MIN_ACT = 12'd500;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX_ACT = 12'd2500;

  // One gain set
  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gain_set_t;

endpackage

// ===== hdl/dual_gain_pid_positional.sv =====
// Dual-gain positional PID controller: input register, one compute pass, result register.
//
// Usage:
//   in_*  : request stream. in_tuser[2:0] is the mode, in_tdata[15:0] the setpoint,
//           in_tdata[31:16] the measurement. Mode 4 runs PID with the depth gains,
//           mode 2 with the orientation gains, any other mode clears the integral
//           and previous error and returns drive 0.
//   out_* : result stream, one result per request, drive in out_tdata[11:0]
//           (1500 +/- 1000 when active, 0 when idle).
//   cfg_* : write-only gain registers 0..5 (depth kp/ki/kd, orient kp/ki/kd),
//           signed Q8.8. Indexes 6 and 7 are ignored. Write only while idle.
// Timing:
//   A request taken into the input register is computed from it, and the result
//   is stored in the result register, which drives out_tvalid.
//   One request per cycle is sustained while out_tready is high; the integral and
//   previous-error update closes within the compute pass, so that loop sets the rate.
//   While out_tready is low the result register holds and the input register
//   takes one more request before in_tready drops.
// Reset: rst_n synchronous, clears the valid flags of both pipeline stages, the integral, the
//   previous error and all gains.
module dual_gain_pid_positional (
  input  logic                                clk,
  input  logic                                rst_n,
  // request stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dgpid_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] setpoint, [31:16] measured
  input  logic [dgpid_pkg::CMD_W-1:0]         in_tuser,   // [2:0] cmd
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dgpid_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [11:0] drive, [15:12] zero
  // gain registers
  input  logic                                cfg_we,
  input  logic [dgpid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dgpid_pkg::GAIN_W-1:0]        cfg_wdata
);

  // Gain registers
  dgpid_pkg::gain_set_t depth_gain_r, orient_gain_r;

  // Input register
  logic                              in_vld_r;
  logic [dgpid_pkg::CMD_W-1:0]       cmd_r;
  logic [dgpid_pkg::VAL_W-1:0]       sp_r;
  logic [dgpid_pkg::VAL_W-1:0]       mv_r;

  // Controller state
  logic signed [dgpid_pkg::INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [dgpid_pkg::ERR_W-1:0]   prev_err_r, prev_err_nxt;

  // Result register
  logic                              out_vld_r;
  logic [dgpid_pkg::DRIVE_W-1:0]     drive_r, drive_nxt;

  logic in_acc, fire;

  // Handshake: stage advances when the result register is free or being drained
  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(dgpid_pkg::OUT_TDATA_W - dgpid_pkg::DRIVE_W){1'b0}}, drive_r};

  // Compute pass
  dgpid_pkg::gain_set_t                  gsel;
  logic                                  active;
  logic signed [dgpid_pkg::ERR_W-1:0]    err;
  logic signed [dgpid_pkg::INTEG_W:0]    isum;
  logic signed [dgpid_pkg::INTEG_W-1:0]  isat;
  logic signed [dgpid_pkg::DIFF_W-1:0]   diff;
  logic signed [dgpid_pkg::PPROP_W-1:0]  p_prop;
  logic signed [dgpid_pkg::PINT_W-1:0]   p_int;
  logic signed [dgpid_pkg::PDER_W-1:0]   p_der;
  logic signed [dgpid_pkg::ACC_W-1:0]    acc, acc_adj;
  logic signed [dgpid_pkg::QUO_W-1:0]    quo;
  logic signed [dgpid_pkg::U_W-1:0]      u;
  logic signed [dgpid_pkg::SUM_W-1:0]    drive_sum;

  always_comb begin
    // gain set by mode
    active = 1'b1;
    unique case (cmd_r)
      dgpid_pkg::MODE_DEPTH:  gsel = depth_gain_r;
      dgpid_pkg::MODE_ORIENT: gsel = orient_gain_r;
      default: begin
        gsel   = depth_gain_r;
        active = 1'b0;
      end
    endcase

    // error and saturating integral
    err  = $signed({1'b0, sp_r}) - $signed({1'b0, mv_r});
    isum = {integ_r[dgpid_pkg::INTEG_W-1], integ_r}
         + (dgpid_pkg::INTEG_W + 1)'(err);
    if (isum[dgpid_pkg::INTEG_W] != isum[dgpid_pkg::INTEG_W-1]) begin
      isat = isum[dgpid_pkg::INTEG_W] ? {1'b1, {(dgpid_pkg::INTEG_W-1){1'b0}}}
                                      : {1'b0, {(dgpid_pkg::INTEG_W-1){1'b1}}};
    end else begin
      isat = isum[dgpid_pkg::INTEG_W-1:0];
    end
    diff = dgpid_pkg::DIFF_W'(prev_err_r) - dgpid_pkg::DIFF_W'(err);

    // three products and the Q8.8 sum
    p_prop = dgpid_pkg::PPROP_W'(gsel.kp) * dgpid_pkg::PPROP_W'(err);
    p_int  = dgpid_pkg::PINT_W'(gsel.ki)  * dgpid_pkg::PINT_W'(isat);
    p_der  = dgpid_pkg::PDER_W'(gsel.kd)  * dgpid_pkg::PDER_W'(diff);
    acc    = dgpid_pkg::ACC_W'(p_prop) + dgpid_pkg::ACC_W'(p_int)
           + dgpid_pkg::ACC_W'(p_der);

    // divide by 256 toward zero: bias negatives before the shift
    acc_adj = acc + (acc[dgpid_pkg::ACC_W-1] ? dgpid_pkg::ACC_W'(255) : '0);
    quo     = acc_adj[dgpid_pkg::ACC_W-1:dgpid_pkg::FRAC_W];

    // clamp to +/-1000
    if (quo > dgpid_pkg::QUO_W'(dgpid_pkg::DRIVE_LIM)) begin
      u = dgpid_pkg::U_W'(dgpid_pkg::DRIVE_LIM);
    end else if (quo < -dgpid_pkg::QUO_W'(dgpid_pkg::DRIVE_LIM)) begin
      u = -dgpid_pkg::U_W'(dgpid_pkg::DRIVE_LIM);
    end else begin
      u = quo[dgpid_pkg::U_W-1:0];
    end
    drive_sum = dgpid_pkg::DRIVE_MID + dgpid_pkg::SUM_W'(u);

    if (active) begin
      integ_nxt    = isat;
      prev_err_nxt = err;
      drive_nxt    = drive_sum[dgpid_pkg::DRIVE_W-1:0];
    end else begin
      integ_nxt    = '0;
      prev_err_nxt = '0;
      drive_nxt    = '0;
    end
  end

  // Control, state and gains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      integ_r       <= '0;
      prev_err_r    <= '0;
      depth_gain_r  <= '0;
      orient_gain_r <= '0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end

      if (fire) begin
        out_vld_r  <= 1'b1;
        integ_r    <= integ_nxt;
        prev_err_r <= prev_err_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_addr)
          dgpid_pkg::REG_DEPTH_KP:  depth_gain_r.kp  <= cfg_wdata;
          dgpid_pkg::REG_DEPTH_KI:  depth_gain_r.ki  <= cfg_wdata;
          dgpid_pkg::REG_DEPTH_KD:  depth_gain_r.kd  <= cfg_wdata;
          dgpid_pkg::REG_ORIENT_KP: orient_gain_r.kp <= cfg_wdata;
          dgpid_pkg::REG_ORIENT_KI: orient_gain_r.ki <= cfg_wdata;
          dgpid_pkg::REG_ORIENT_KD: orient_gain_r.kd <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
      sp_r  <= in_tdata[dgpid_pkg::VAL_W-1:0];
      mv_r  <= in_tdata[2*dgpid_pkg::VAL_W-1:dgpid_pkg::VAL_W];
    end
    if (fire) begin
      drive_r <= drive_nxt;
    end
  end

`ifndef SYNTHESIS
  // Drive is zero or inside the active band
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (drive_r == '0) ||
                  ((drive_r >= dgpid_pkg::DRIVE_MIN_ACT) &&
                   (drive_r <= dgpid_pkg::DRIVE_MAX_ACT)))
    else $error("drive out of range");

  // Controller state moves only when an item is computed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(integ_r) && $stable(prev_err_r))
    else $error("state changed without an item");

  // Idle mode clears state and yields zero drive
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !active |=> integ_r == '0 && prev_err_r == '0 && drive_r == '0)
    else $error("idle mode did not clear");

  // Active mode stores the error just used
  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    fire && active |=> prev_err_r == $past(err))
    else $error("previous error not stored");
`endif

endmodule

// ===== dv/dgpid_drive_checker.sv =====
// Drive-value checker for the dual-gain PID block: tracks gain writes, predicts, compares.
module dgpid_drive_checker
  import dgpid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] setpoint, [31:16] measured
  input  logic [CMD_W-1:0]       in_tuser,   // [2:0] cmd
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] drive, [15:12] zero
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [GAIN_W-1:0]      cfg_wdata,
  output int                     drive_errors,
  output int                     drive_backlog
);

  localparam longint INTEG_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint INTEG_MIN = -64'sh0000_0000_8000_0000;
  localparam longint Q_SCALE   = 64'sd1 << FRAC_W;

  // Mirrored gain registers and loop state
  gain_set_t                 depth_gains;
  gain_set_t                 orient_gains;
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [ERR_W-1:0]   last_err;

  // Drive values still owed by the block, oldest first
  logic [DRIVE_W-1:0]        expected_drive[$];
  logic [DRIVE_W-1:0]        want_drive;
  int                        err_cnt = 0;

  // Next drive value for one request; updates integral and previous error
  function automatic logic [DRIVE_W-1:0] predict_drive(input logic [CMD_W-1:0] cmd,
                                                       input logic [VAL_W-1:0] sp,
                                                       input logic [VAL_W-1:0] mv);
    gain_set_t g;
    longint    e;
    longint    integ_next;
    longint    acc;
    longint    u;
    if (cmd == MODE_DEPTH) begin
      g = depth_gains;
    end else if (cmd == MODE_ORIENT) begin
      g = orient_gains;
    end else begin
      // idle modes wipe the loop state
      integ_acc = '0;
      last_err  = '0;
      return '0;
    end
    e = longint'(sp) - longint'(mv);
    integ_next = longint'(integ_acc) + e;
    if (integ_next > INTEG_MAX) integ_next = INTEG_MAX;
    else if (integ_next < INTEG_MIN) integ_next = INTEG_MIN;
    acc = longint'(g.kp) * e
        + longint'(g.ki) * integ_next
        + longint'(g.kd) * (longint'(last_err) - e);
    // signed division rounds toward zero
    u = acc / Q_SCALE;
    if (u > DRIVE_LIM) u = DRIVE_LIM;
    else if (u < -DRIVE_LIM) u = -DRIVE_LIM;
    integ_acc = INTEG_W'(integ_next);
    last_err  = ERR_W'(e);
    return DRIVE_W'(longint'(DRIVE_MID) + u);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      depth_gains  = '0;
      orient_gains = '0;
      integ_acc    = '0;
      last_err     = '0;
      expected_drive.delete();
    end else begin
      // gain register writes; spare indexes are dropped
      if (cfg_we) begin
        case (cfg_addr)
          REG_DEPTH_KP:  depth_gains.kp  = cfg_wdata;
          REG_DEPTH_KI:  depth_gains.ki  = cfg_wdata;
          REG_DEPTH_KD:  depth_gains.kd  = cfg_wdata;
          REG_ORIENT_KP: orient_gains.kp = cfg_wdata;
          REG_ORIENT_KI: orient_gains.ki = cfg_wdata;
          REG_ORIENT_KD: orient_gains.kd = cfg_wdata;
          default: ;
        endcase
      end

      // compare first, so a request taken on the same edge cannot match itself
      if (out_tvalid && out_tready) begin
        if (expected_drive.size() == 0) begin
          $error("drive: unexpected result, actual %0d", out_tdata[DRIVE_W-1:0]);
          err_cnt++;
        end else begin
          want_drive = expected_drive.pop_front();
          if (out_tdata[DRIVE_W-1:0] !== want_drive) begin
            $error("drive mismatch: expected %0d, actual %0d",
                   want_drive, out_tdata[DRIVE_W-1:0]);
            err_cnt++;
          end
        end
        if (out_tdata[OUT_TDATA_W-1:DRIVE_W] !== '0) begin
          $error("pad mismatch: expected 0, actual %0d", out_tdata[OUT_TDATA_W-1:DRIVE_W]);
          err_cnt++;
        end
      end

      if (in_tvalid && in_tready) begin
        expected_drive.push_back(predict_drive(in_tuser, in_tdata[VAL_W-1:0],
                                               in_tdata[IN_TDATA_W-1:VAL_W]));
      end
    end
    drive_errors  <= err_cnt;
    drive_backlog <= expected_drive.size();
  end

endmodule

// ===== dv/tb_dual_gain_pid_positional.sv =====
// Testbench top for the dual-gain PID block: clock, reset, stimulus, back-pressure, verdict.
module tb_dual_gain_pid_positional;
  import dgpid_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_IDLE     = 17;
  localparam int CMD_VALUES   = 1 << CMD_W;
  localparam int VAL_MAX      = (1 << VAL_W) - 1;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_A    = 400;
  localparam int HOLD_AT_B    = 1200;
  localparam int DRAIN_CYCLES = 4;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 160;
  localparam int EXT_ITEMS    = 100;
  localparam int SAT_ITEMS    = 25;

  localparam logic [CFG_ADDR_W-1:0]    REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0]    REG_SPARE_7 = 3'd7;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX    = 16'sh7FFF;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN    = 16'sh8000;
  localparam logic signed [GAIN_W-1:0] GAIN_ONE    = 16'sd256;
  localparam logic signed [GAIN_W-1:0] GAIN_ZERO   = 16'sd0;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;    // [15:0] setpoint, [31:16] measured
  logic [CMD_W-1:0]       in_tuser  = '0;    // [2:0] cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [11:0] drive, [15:12] zero
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [GAIN_W-1:0]      cfg_wdata = '0;

  int drive_errors;
  int drive_backlog;
  int cycle_cnt    = 0;
  int tx_max_gap   = MAX_IDLE;
  int rx_max_stall = MAX_IDLE;

  always #CLK_HALF clk = ~clk;

  dual_gain_pid_positional dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  dgpid_drive_checker drive_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .drive_errors  (drive_errors),
    .drive_backlog (drive_backlog)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL dual_gain_pid_positional");
      $finish;
    end
  end

  // Result sink: random stalls, plus two long hold-offs to back the block up
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == HOLD_AT_A || taken == HOLD_AT_B) stall = HOLD_CYCLES;
      else stall = $urandom_range(rx_max_stall, 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  function automatic logic [CMD_W-1:0] pick_active();
    return ($urandom_range(1) == 0) ? MODE_DEPTH : MODE_ORIENT;
  endfunction

  function automatic logic [CMD_W-1:0] pick_idle();
    logic [CMD_W-1:0] c;
    do c = CMD_W'($urandom); while (c == MODE_DEPTH || c == MODE_ORIENT);
    return c;
  endfunction

  // Mostly modest gains so the drive stays off the rails; some full-range
  function automatic logic signed [GAIN_W-1:0] rand_gain();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return GAIN_W'($urandom);
    else if (pick < 5) return GAIN_W'(int'($urandom_range(128)) - 64);
    else return GAIN_W'(int'($urandom_range(1024)) - 512);
  endfunction

  // One request, after a random gap; leaves valid high for back-to-back issue
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] sp,
                              input logic [VAL_W-1:0] mv);
    int gap;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {mv, sp};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly active requests with measurement near setpoint; some idle and raw noise
  task automatic send_random();
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] sp;
    logic [VAL_W-1:0] mv;
    int               pick;
    int               span;
    int               m;
    pick = $urandom_range(99);
    sp   = VAL_W'($urandom);
    if (pick < 80) begin
      cmd  = pick_active();
      span = ($urandom_range(9) == 0) ? VAL_MAX : (($urandom_range(3) == 0) ? 4000 : 300);
      m    = int'(sp) + int'($urandom_range(2 * span)) - span;
      if (m < 0) m = 0;
      if (m > VAL_MAX) m = VAL_MAX;
      mv = VAL_W'(m);
    end else if (pick < 90) begin
      cmd = pick_idle();
      mv  = VAL_W'($urandom);
    end else begin
      cmd = CMD_W'($urandom);
      mv  = VAL_W'($urandom);
    end
    send_request(cmd, sp, mv);
  endtask

  task automatic write_gain(input logic [CFG_ADDR_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Full register load, including writes to the unused indexes
  task automatic load_gains(input gain_set_t d, input gain_set_t o);
    write_gain(REG_DEPTH_KP, d.kp);
    write_gain(REG_DEPTH_KI, d.ki);
    write_gain(REG_DEPTH_KD, d.kd);
    write_gain(REG_SPARE_6, GAIN_W'($urandom));
    write_gain(REG_ORIENT_KP, o.kp);
    write_gain(REG_ORIENT_KI, o.ki);
    write_gain(REG_ORIENT_KD, o.kd);
    write_gain(REG_SPARE_7, GAIN_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Stop issuing and wait until every owed result has come back
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (drive_backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Same-sign error run with full-scale error to wind the integral up
  task automatic sat_run(input int n, input bit rising);
    for (int i = 0; i < n; i++) begin
      if (rising) send_request(pick_active(), VAL_W'(VAL_MAX), VAL_W'($urandom_range(15)));
      else send_request(pick_active(), VAL_W'($urandom_range(15)), VAL_W'(VAL_MAX));
    end
  endtask

  initial begin : stimulus
    gain_set_t dset;
    gain_set_t oset;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gains at reset value: active modes sit at mid-scale
    send_request(MODE_DEPTH, VAL_W'(VAL_MAX), '0);
    send_request(MODE_ORIENT, '0, VAL_W'(VAL_MAX));
    send_request(pick_idle(), 16'h1234, 16'h4321);
    quiesce();

    // directed: unity depth gain, mixed orientation gains
    dset = '{kp: GAIN_ONE, ki: GAIN_ZERO, kd: GAIN_ZERO};
    oset = '{kp: -16'sd200, ki: 16'sd1, kd: 16'sd512};
    load_gains(dset, oset);
    send_request(MODE_DEPTH, VAL_W'(VAL_MAX), '0);   // clamps high
    send_request(MODE_DEPTH, '0, VAL_W'(VAL_MAX));   // clamps low
    send_request(MODE_DEPTH, 16'd1100, 16'd1000);
    send_request(pick_idle(), '0, '0);
    send_request(MODE_ORIENT, 16'd3, 16'd0);         // negative quotient, rounds toward zero
    send_request(MODE_ORIENT, VAL_W'(VAL_MAX), VAL_W'(VAL_MAX));
    send_request(MODE_ORIENT, '0, '0);
    for (int c = 0; c < CMD_VALUES; c++) send_request(CMD_W'(c), 16'h5A5A, 16'hA5A5);
    send_request(MODE_DEPTH, 16'hA5A5, 16'h5A5A);
    quiesce();

    // gain extremes, both polarities
    dset = '{kp: GAIN_MAX, ki: GAIN_MAX, kd: GAIN_MAX};
    oset = '{kp: GAIN_MIN, ki: GAIN_MIN, kd: GAIN_MIN};
    load_gains(dset, oset);
    repeat (EXT_ITEMS) send_random();
    quiesce();
    load_gains(oset, dset);
    repeat (EXT_ITEMS) send_random();
    quiesce();

    // random gains, rotating through idle profiles
    for (int p = 0; p < RAND_PHASES; p++) begin
      tx_max_gap   = (p % 4 == 0 || p % 4 == 2) ? MAX_IDLE : 0;
      rx_max_stall = (p % 4 == 0 || p % 4 == 3) ? MAX_IDLE : 0;
      dset.kp = rand_gain();
      dset.ki = rand_gain();
      dset.kd = rand_gain();
      oset.kp = rand_gain();
      oset.ki = rand_gain();
      oset.kd = rand_gain();
      load_gains(dset, oset);
      repeat (PHASE_ITEMS) send_random();
      quiesce();
    end

    // integral wind-up both ways, full rate
    tx_max_gap   = 0;
    rx_max_stall = 0;
    dset = '{kp: GAIN_ZERO, ki: 16'sd1, kd: GAIN_ZERO};
    load_gains(dset, dset);
    sat_run(SAT_ITEMS, 1'b1);
    sat_run(2 * SAT_ITEMS, 1'b0);
    sat_run(SAT_ITEMS, 1'b1);
    quiesce();

    if (drive_errors == 0 && drive_backlog == 0) begin
      $display("PASS dual_gain_pid_positional");
    end else begin
      $display("FAIL dual_gain_pid_positional");
    end
    $finish;
  end

endmodule
